// ===== design/pcss_pkg.sv =====
// Shared types, widths and codes for the peer clock slew sync block.
// No dependencies; every other design file refers to this package by scoped names.
package pcss_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned IdW     = 16;
    localparam int unsigned LimW    = 31;
    localparam int unsigned ActW    = 2;
    localparam int unsigned CfgIdxW = 2;

    // action codes
    localparam logic [ActW-1:0] ACT_INIT    = 2'd0;
    localparam logic [ActW-1:0] ACT_QUERY   = 2'd1;
    localparam logic [ActW-1:0] ACT_OBSERVE = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_LEAD = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STEP     = 2'd2;

    localparam logic [IdW-1:0]  OWN_ID_RST   = 16'd0;
    localparam logic [LimW-1:0] MAX_LEAD_RST = 31'd5000;
    localparam logic [LimW-1:0] STEP_RST     = 31'd50;

    // seed conflict window, ms
    localparam logic signed [TimeW-1:0] LEAD_WINDOW     = 32'sd300;
    localparam logic signed [TimeW-1:0] NEG_LEAD_WINDOW = -32'sd300;

    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [TimeW-1:0] now_ms;
        logic [TimeW-1:0] remote_seed;
        logic [TimeW-1:0] peer_time;
        logic [IdW-1:0]   peer_id;
        logic             peer_anchor;
    } t_in_beat;

    typedef struct packed {
        logic [TimeW-1:0] game_time;
        logic             adopted;
        logic [TimeW-1:0] session_seed;
    } t_out_beat;

    typedef struct packed {
        logic [TimeW-1:0] seed;
        logic [TimeW-1:0] epoch;
        logic [TimeW-1:0] slew;
    } t_clk_state;

    typedef struct packed {
        logic [IdW-1:0]  own_player_id;
        logic [LimW-1:0] max_lead;
        logic [LimW-1:0] slew_step;
    } t_cfg;

endpackage

// ===== design/pcss_if.sv =====
// Valid/ready channel interfaces for input and result beats.
// Depends on pcss_pkg for field widths.
interface pcss_in_if;
    logic                        valid;
    logic                        ready;
    logic [pcss_pkg::ActW-1:0]   action;
    logic [pcss_pkg::TimeW-1:0]  now_ms;
    logic [pcss_pkg::TimeW-1:0]  remote_seed;
    logic [pcss_pkg::TimeW-1:0]  peer_time;
    logic [pcss_pkg::IdW-1:0]    peer_id;
    logic                        peer_anchor;

    modport source (output valid, action, now_ms, remote_seed, peer_time, peer_id,
                    peer_anchor, input ready);
    modport sink   (input valid, action, now_ms, remote_seed, peer_time, peer_id,
                    peer_anchor, output ready);
endinterface

interface pcss_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcss_pkg::TimeW-1:0]  game_time;
    logic                        adopted;
    logic [pcss_pkg::TimeW-1:0]  session_seed;

    modport source (output valid, game_time, adopted, session_seed, input ready);
    modport sink   (input valid, game_time, adopted, session_seed, output ready);
endinterface

// ===== design/pcss_cfg_regs.sv =====
// Configuration registers: own id, plausible lead limit, catch-up step.
// Depends on pcss_pkg.
module pcss_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcss_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pcss_pkg::LimW-1:0]     i_cfg_wdata,
    output pcss_pkg::t_cfg                o_cfg
);
    pcss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_player_id <= pcss_pkg::OWN_ID_RST;
            r_cfg.max_lead      <= pcss_pkg::MAX_LEAD_RST;
            r_cfg.slew_step     <= pcss_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcss_pkg::CFG_OWN_ID:   r_cfg.own_player_id <= i_cfg_wdata[pcss_pkg::IdW-1:0];
                pcss_pkg::CFG_MAX_LEAD: r_cfg.max_lead      <= i_cfg_wdata;
                pcss_pkg::CFG_STEP:     r_cfg.slew_step     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== design/pcss_step.sv =====
// Per-beat datapath: game time, peer lead, adoption and slew update.
// Depends on pcss_pkg.
module pcss_step (
    input  pcss_pkg::t_in_beat    i_beat,
    input  pcss_pkg::t_clk_state  i_state,
    input  pcss_pkg::t_cfg        i_cfg,
    output pcss_pkg::t_clk_state  o_state,
    output pcss_pkg::t_out_beat   o_result
);
    logic [pcss_pkg::TimeW-1:0] my_time;
    logic [pcss_pkg::TimeW-1:0] lead;
    logic                       seed_diff;
    logic                       adopt_ok;
    logic                       lead_pos;
    logic                       over;
    logic [pcss_pkg::LimW-1:0]  eff;
    logic [pcss_pkg::LimW-1:0]  inc;
    logic [pcss_pkg::TimeW-1:0] inc_w;

    always_comb begin
        my_time   = i_beat.now_ms - i_state.epoch + i_state.slew;
        lead      = i_beat.peer_time - my_time;
        seed_diff = i_beat.remote_seed != i_state.seed;
        adopt_ok  = ($signed(lead) > pcss_pkg::LEAD_WINDOW) ||
                    (($signed(lead) > pcss_pkg::NEG_LEAD_WINDOW) &&
                     (i_beat.peer_id < i_cfg.own_player_id));
        lead_pos  = !lead[pcss_pkg::TimeW-1] && (|lead[pcss_pkg::LimW-1:0]);
        over      = !lead[pcss_pkg::TimeW-1] && (lead[pcss_pkg::LimW-1:0] > i_cfg.max_lead);
        // anchor peers get their lead clamped, others past the limit are ignored
        eff       = over ? i_cfg.max_lead : lead[pcss_pkg::LimW-1:0];
        inc       = (eff < i_cfg.slew_step) ? eff : i_cfg.slew_step;
        inc_w     = (lead_pos && (!over || i_beat.peer_anchor)) ? {1'b0, inc} : '0;

        o_state               = i_state;
        o_result.game_time    = my_time;
        o_result.adopted      = 1'b0;

        case (i_beat.action)
            pcss_pkg::ACT_INIT: begin
                o_state.seed       = i_beat.remote_seed;
                o_state.epoch      = i_beat.now_ms;
                o_state.slew       = '0;
                o_result.game_time = '0;
            end
            pcss_pkg::ACT_OBSERVE: begin
                if (seed_diff) begin
                    if (adopt_ok) begin
                        o_state.seed       = i_beat.remote_seed;
                        o_state.epoch      = i_beat.now_ms - i_beat.peer_time;
                        o_state.slew       = '0;
                        o_result.game_time = i_beat.peer_time;
                        o_result.adopted   = 1'b1;
                    end
                end else begin
                    o_state.slew       = i_state.slew + inc_w;
                    o_result.game_time = my_time + inc_w;
                end
            end
            default: ;  // query and the unused code only report
        endcase

        o_result.session_seed = o_state.seed;
    end
endmodule

// ===== design/peer_clock_slew_sync_core.sv =====
// Top level of the peer clock slew sync block: input register, datapath, result register.
// Depends on pcss_pkg, pcss_if, pcss_cfg_regs and pcss_step.
//
// Keeps a session seed and a game clock (now - epoch + slew, mod 2^32). One beat is taken
// per cycle while input ready is high; each accepted beat is held in the input register and
// its result is then registered in the result register, which presents it. The session state
// updates in a single pass through the datapath between the input register and the result
// register, so consecutive beats see each other's updates in order. Input ready drops only
// when both stages are full and the result is not taken. Write configuration only while idle.
module peer_clock_slew_sync_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcss_in_if.sink                       i_in,
    pcss_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [pcss_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pcss_pkg::LimW-1:0]     i_cfg_wdata
);
    pcss_pkg::t_cfg       cfg;
    pcss_pkg::t_in_beat   in_beat;
    pcss_pkg::t_clk_state n_state;
    pcss_pkg::t_out_beat  n_out;

    logic                 r_in_valid;
    pcss_pkg::t_in_beat   r_in;
    logic                 r_out_valid;
    pcss_pkg::t_out_beat  r_out;
    pcss_pkg::t_clk_state r_state;

    logic advance;
    logic in_take;

    pcss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pcss_step u_step (
        .i_beat   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign in_beat.action      = i_in.action;
    assign in_beat.now_ms      = i_in.now_ms;
    assign in_beat.remote_seed = i_in.remote_seed;
    assign in_beat.peer_time   = i_in.peer_time;
    assign in_beat.peer_id     = i_in.peer_id;
    assign in_beat.peer_anchor = i_in.peer_anchor;

    // result slot free (or being drained) lets the input stage move on
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_beat;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.game_time    = r_out.game_time;
    assign o_out.adopted      = r_out.adopted;
    assign o_out.session_seed = r_out.session_seed;
endmodule

// ===== design/pcss_checker.sv =====
// Port-level checks on the peer clock slew sync top level, attached by bind.
// Depends on pcss_pkg and peer_clock_slew_sync_core.
module pcss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pcss_pkg::TimeW-1:0]   i_game_time,
    input logic                         i_adopted,
    input logic [pcss_pkg::TimeW-1:0]   i_session_seed
);
    // nothing comes out right after reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_game_time) && $stable(i_adopted) &&
             $stable(i_session_seed)))
        else $error("stalled result beat changed");

    // beat taken while the result is stalled fills the pipe: no room until drained
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && i_in_valid && i_in_ready) |=>
            (!i_in_ready || i_out_ready))
        else $error("input ready while both stages full");
endmodule

bind peer_clock_slew_sync_core pcss_checker u_pcss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_game_time    (o_out.game_time),
    .i_adopted      (o_out.adopted),
    .i_session_seed (o_out.session_seed)
);
